@@ hdl/etr_pkg.sv @@
package etr_pkg;

    localparam int CP_W             = 21;
    localparam int HYPHEN_SLOTS     = 4;
    localparam int MAX_HELD_HYPHENS = 15;

    // Configuration register file.
    localparam int CFG_CODES = 4;
    localparam int CFG_IDX_W = 3;
    localparam int SLOTS_W   = 3;

    // Held hyphen count and the back end's element counter.
    localparam int CNT_W = $clog2(MAX_HELD_HYPHENS + 1);
    localparam int IDX_W = (CNT_W > 2) ? CNT_W : 2;

    // Command queue between the front and back ends.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CP_W-1:0] CP_LIG_FF       = 21'h0FB00;
    localparam logic [CP_W-1:0] CP_LIG_FI       = 21'h0FB01;
    localparam logic [CP_W-1:0] CP_LIG_FL       = 21'h0FB02;
    localparam logic [CP_W-1:0] CP_LIG_FFI      = 21'h0FB03;
    localparam logic [CP_W-1:0] CP_LIG_FFL      = 21'h0FB04;
    localparam logic [CP_W-1:0] CP_LIG_LONG_ST  = 21'h0FB05;
    localparam logic [CP_W-1:0] CP_LIG_ST       = 21'h0FB06;
    localparam logic [CP_W-1:0] CP_SOFT_HYPHEN  = 21'h000AD;
    localparam logic [CP_W-1:0] CP_EN_DASH      = 21'h02013;
    localparam logic [CP_W-1:0] CP_REPLACEMENT  = 21'h0FFFD;
    localparam logic [CP_W-1:0] CP_PUA_FIRST    = 21'h0E000;
    localparam logic [CP_W-1:0] CP_PUA_LAST     = 21'h0F8FF;
    localparam logic [CP_W-1:0] CP_TAB          = 21'h00009;
    localparam logic [CP_W-1:0] CP_SPACE        = 21'h00020;
    localparam logic [CP_W-1:0] CP_NBSP         = 21'h000A0;
    localparam logic [CP_W-1:0] CP_HYPHEN_MINUS = 21'h0002D;
    localparam logic [CP_W-1:0] CP_DIGIT_0      = 21'h00030;
    localparam logic [CP_W-1:0] CP_DIGIT_9      = 21'h00039;
    localparam logic [CP_W-1:0] CP_DEL          = 21'h0007F;
    localparam logic [CP_W-1:0] CP_C1_LAST      = 21'h0009F;
    localparam logic [CP_W-1:0] CP_LOWER_F      = 21'h00066;
    localparam logic [CP_W-1:0] CP_LOWER_I      = 21'h00069;
    localparam logic [CP_W-1:0] CP_LOWER_L      = 21'h0006C;
    localparam logic [CP_W-1:0] CP_LOWER_S      = 21'h00073;
    localparam logic [CP_W-1:0] CP_LOWER_T      = 21'h00074;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HYPHEN_A   = 3'd0,
        CFG_HYPHEN_B   = 3'd1,
        CFG_HYPHEN_C   = 3'd2,
        CFG_HYPHEN_D   = 3'd3,
        CFG_SLOTS_USED = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_TEXT,
        CMD_LIG,
        CMD_RUN
    } cmd_kind_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_SPACE,
        PH_MAIN,
        PH_DASH,
        PH_END
    } back_phase_t;

    // One decided code point as the back end carries it out.
    typedef struct packed {
        logic             space;
        cmd_kind_t        kind;
        logic [CP_W-1:0]  cp;
        logic             fffd;
        logic [CNT_W-1:0] dashes;
        logic             line_end;
    } cmd_t;

    function automatic logic is_digit(logic [CP_W-1:0] cp);
        return (cp >= CP_DIGIT_0) && (cp <= CP_DIGIT_9);
    endfunction

    function automatic logic is_unmapped(logic [CP_W-1:0] cp);
        return ((cp < CP_SPACE) && (cp != CP_TAB)) ||
               ((cp >= CP_DEL) && (cp <= CP_C1_LAST)) ||
               ((cp >= CP_PUA_FIRST) && (cp <= CP_PUA_LAST)) ||
               (cp == CP_REPLACEMENT);
    endfunction

    function automatic logic is_blank(logic [CP_W-1:0] cp);
        return (cp == CP_SPACE) || (cp == CP_TAB) || (cp == CP_NBSP);
    endfunction

    function automatic logic is_ligature(logic [CP_W-1:0] cp);
        return (cp >= CP_LIG_FF) && (cp <= CP_LIG_ST);
    endfunction

    // Position of the last letter of a ligature's expansion.
    function automatic logic [1:0] lig_last(logic [CP_W-1:0] lig);
        logic [1:0] last;
        case (lig)
            CP_LIG_FFI, CP_LIG_FFL: last = 2'd2;
            default:                last = 2'd1;
        endcase
        return last;
    endfunction

    function automatic logic [CP_W-1:0] lig_char(logic [CP_W-1:0] lig, logic [1:0] pos);
        logic [CP_W-1:0] ch;
        case (lig)
            CP_LIG_FF:  ch = CP_LOWER_F;
            CP_LIG_FI:  ch = (pos == 2'd0) ? CP_LOWER_F : CP_LOWER_I;
            CP_LIG_FL:  ch = (pos == 2'd0) ? CP_LOWER_F : CP_LOWER_L;
            CP_LIG_FFI: ch = (pos == 2'd2) ? CP_LOWER_I : CP_LOWER_F;
            CP_LIG_FFL: ch = (pos == 2'd2) ? CP_LOWER_L : CP_LOWER_F;
            default:    ch = (pos == 2'd0) ? CP_LOWER_S : CP_LOWER_T;
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/etr_raw_if.sv @@
interface etr_raw_if;
    import etr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            line_end;

    modport source (output valid, code_point, line_end, input ready);
    modport sink   (input valid, code_point, line_end, output ready);
endinterface

@@ hdl/etr_clean_if.sv @@
interface etr_clean_if;
    import etr_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] out_code_point;
    logic            out_line_end;
    logic            line_empty;

    modport source (output valid, out_code_point, out_line_end, line_empty, input ready);
    modport sink   (input valid, out_code_point, out_line_end, line_empty, output ready);
endinterface

@@ hdl/etr_cfg_if.sv @@
interface etr_cfg_if;
    import etr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CP_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/etr_front.sv @@
module etr_front (
    input  logic          clk,
    input  logic          rst_n,
    etr_raw_if.sink       raw,
    etr_cfg_if.sink       cfg,
    output etr_pkg::cmd_t cmd,
    output logic          cmd_push,
    input  logic          q_full
);
    import etr_pkg::*;

    logic [CP_W-1:0]    hyph_code_reg [CFG_CODES];
    logic [SLOTS_W-1:0] slots_used_reg;

    logic [CP_W-1:0]  held_point_reg, held_point_next;
    logic             held_valid_reg, held_valid_next;
    logic             bh_digit_reg, bh_digit_next;
    logic             bh_unm_reg, bh_unm_next;
    logic             run_open_reg, run_open_next;
    logic             run_digit_reg, run_digit_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic             space_pend_reg, space_pend_next;
    logic             emitted_reg, emitted_next;
    logic             final_pend_reg, final_pend_next;

    logic             accept, final_go, dec_go;
    logic             has_next, next_unm, next_dig, cur_unm, hyph, has_push, space_set;
    logic             run_open_d, run_digit_d, fffd;
    logic [CNT_W-1:0] run_cnt_d, dashes;
    logic [CP_W-1:0]  out_cp;
    cmd_kind_t        kind;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CFG_CODES; k++)
            begin
                hyph_code_reg[k] <= '0;
            end
            slots_used_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_HYPHEN_A:   hyph_code_reg[0] <= cfg.data;
                CFG_HYPHEN_B:   hyph_code_reg[1] <= cfg.data;
                CFG_HYPHEN_C:   hyph_code_reg[2] <= cfg.data;
                CFG_HYPHEN_D:   hyph_code_reg[3] <= cfg.data;
                CFG_SLOTS_USED: slots_used_reg   <= cfg.data[SLOTS_W-1:0];
                default:        ;
            endcase
        end
    end

    // After a line-end transaction the front end takes no input while the last
    // code point is decided on its own, with nothing after it.
    assign raw.ready = !final_pend_reg && !q_full;
    assign accept    = raw.valid && raw.ready;
    assign final_go  = final_pend_reg && !q_full;
    assign dec_go    = (accept && held_valid_reg) || final_go;

    // Decide the held code point from its neighbors.
    always_comb
    begin
        has_next = !final_pend_reg;
        next_unm = has_next && is_unmapped(raw.code_point);
        next_dig = has_next && is_digit(raw.code_point);
        cur_unm  = is_unmapped(held_point_reg);

        hyph = 1'b0;
        for (int k = 0; k < CFG_CODES; k++)
        begin
            if ((k < HYPHEN_SLOTS) && (SLOTS_W'(k) < slots_used_reg) &&
                (hyph_code_reg[k] == held_point_reg))
            begin
                hyph = 1'b1;
            end
        end

        kind        = CMD_NONE;
        out_cp      = held_point_reg;
        fffd        = 1'b0;
        dashes      = '0;
        run_open_d  = run_open_reg;
        run_digit_d = run_digit_reg;
        run_cnt_d   = run_cnt_reg;
        space_set   = 1'b0;

        if (is_ligature(held_point_reg))
        begin
            kind = CMD_LIG;
        end
        else if ((held_point_reg == CP_SOFT_HYPHEN) && has_next)
        begin
            kind = CMD_NONE;
        end
        else if (hyph)
        begin
            if (run_open_reg)
            begin
                if (run_cnt_reg < CNT_W'(MAX_HELD_HYPHENS))
                begin
                    run_cnt_d = run_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                kind   = CMD_TEXT;
                out_cp = (bh_digit_reg && next_dig) ? CP_EN_DASH : CP_HYPHEN_MINUS;
            end
        end
        else if (cur_unm)
        begin
            if (!bh_unm_reg)
            begin
                run_open_d  = 1'b1;
                run_digit_d = bh_digit_reg;
                run_cnt_d   = '0;
            end
        end
        else if (is_blank(held_point_reg))
        begin
            space_set = emitted_reg;
        end
        else
        begin
            kind = CMD_TEXT;
        end

        // The run closes on its last unmapped member.
        if (run_open_d && cur_unm && !next_unm)
        begin
            fffd   = run_digit_d || next_dig;
            dashes = run_cnt_d;
            if (fffd || (run_cnt_d != '0))
            begin
                kind = CMD_RUN;
            end
            run_open_d  = 1'b0;
            run_digit_d = 1'b0;
            run_cnt_d   = '0;
        end

        has_push = (kind != CMD_NONE);
    end

    always_comb
    begin
        cmd.space    = space_pend_reg && has_push;
        cmd.kind     = kind;
        cmd.cp       = out_cp;
        cmd.fffd     = fffd;
        cmd.dashes   = dashes;
        cmd.line_end = final_pend_reg;
        cmd_push     = dec_go && (has_push || final_pend_reg);
    end

    always_comb
    begin
        held_point_next = held_point_reg;
        held_valid_next = held_valid_reg;
        bh_digit_next   = bh_digit_reg;
        bh_unm_next     = bh_unm_reg;
        run_open_next   = run_open_reg;
        run_digit_next  = run_digit_reg;
        run_cnt_next    = run_cnt_reg;
        space_pend_next = space_pend_reg;
        emitted_next    = emitted_reg;
        final_pend_next = final_pend_reg;

        if (final_go)
        begin
            held_valid_next = 1'b0;
            bh_digit_next   = 1'b0;
            bh_unm_next     = 1'b0;
            run_open_next   = 1'b0;
            run_digit_next  = 1'b0;
            run_cnt_next    = '0;
            space_pend_next = 1'b0;
            emitted_next    = 1'b0;
            final_pend_next = 1'b0;
        end
        else if (accept)
        begin
            if (held_valid_reg)
            begin
                bh_digit_next   = is_digit(held_point_reg);
                bh_unm_next     = cur_unm;
                run_open_next   = run_open_d;
                run_digit_next  = run_digit_d;
                run_cnt_next    = run_cnt_d;
                space_pend_next = has_push ? 1'b0 : (space_set || space_pend_reg);
                emitted_next    = emitted_reg || has_push;
            end
            held_point_next = raw.code_point;
            held_valid_next = 1'b1;
            final_pend_next = raw.line_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            bh_digit_reg   <= 1'b0;
            bh_unm_reg     <= 1'b0;
            run_open_reg   <= 1'b0;
            run_digit_reg  <= 1'b0;
            run_cnt_reg    <= '0;
            space_pend_reg <= 1'b0;
            emitted_reg    <= 1'b0;
            final_pend_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            bh_digit_reg   <= bh_digit_next;
            bh_unm_reg     <= bh_unm_next;
            run_open_reg   <= run_open_next;
            run_digit_reg  <= run_digit_next;
            run_cnt_reg    <= run_cnt_next;
            space_pend_reg <= space_pend_next;
            emitted_reg    <= emitted_next;
            final_pend_reg <= final_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_point_reg <= held_point_next;
    end

    a_final_has_held: assert property (@(posedge clk) disable iff (!rst_n)
        final_pend_reg |-> held_valid_reg)
        else $error("line end pending without a held code point");

    a_line_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd.line_end) |=> (!held_valid_reg && !emitted_reg && !run_open_reg))
        else $error("line state not cleared after the line end");

endmodule

@@ hdl/etr_cmd_fifo.sv @@
module etr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  etr_pkg::cmd_t wr_cmd,
    input  logic          push,
    output logic          full,
    output etr_pkg::cmd_t rd_cmd,
    output logic          rd_valid,
    input  logic          pop
);
    import etr_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + FIFO_CNT_W'(1);
            2'b01:   count_next = count_reg - FIFO_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("command queue overfilled");

endmodule

@@ hdl/etr_back.sv @@
module etr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  etr_pkg::cmd_t head,
    input  logic          head_valid,
    output logic          pop,
    etr_clean_if.source   clean
);
    import etr_pkg::*;

    back_phase_t      phase_reg, phase_next, cur_phase;
    logic [IDX_W-1:0] idx_reg, idx_next, cur_idx;
    logic [CP_W-1:0]  ready_cp_reg, ready_cp_next;
    logic             ready_valid_reg, ready_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [CP_W-1:0]  out_cp_reg, out_cp_next;
    logic             out_end_reg, out_end_next;
    logic             out_empty_reg, out_empty_next;

    logic             end_step, emits_out, out_free, step, finish;
    logic [CP_W-1:0]  push_cp;

    function automatic back_phase_t body_phase(cmd_t c);
        back_phase_t p;
        case (c.kind)
            CMD_TEXT, CMD_LIG: p = PH_MAIN;
            CMD_RUN:           p = c.fffd ? PH_MAIN : PH_DASH;
            default:           p = PH_END;
        endcase
        return p;
    endfunction

    assign cur_phase = (phase_reg == PH_START) ?
                       (head.space ? PH_SPACE : body_phase(head)) : phase_reg;
    assign cur_idx   = (phase_reg == PH_START) ? '0 : idx_reg;

    // Output side: one element of the current command per step. The newest
    // pushed code point waits in the ready register so that the end mark
    // can ride on it.
    always_comb
    begin
        end_step = 1'b0;
        push_cp  = CP_SPACE;
        case (cur_phase)
            PH_SPACE: push_cp = CP_SPACE;
            PH_MAIN:
            begin
                case (head.kind)
                    CMD_TEXT: push_cp = head.cp;
                    CMD_LIG:  push_cp = lig_char(head.cp, cur_idx[1:0]);
                    default:  push_cp = CP_REPLACEMENT;
                endcase
            end
            PH_DASH:  push_cp = CP_HYPHEN_MINUS;
            PH_END:   end_step = 1'b1;
            default:  end_step = 1'b0;
        endcase
        emits_out = end_step || ready_valid_reg;
        out_free  = !out_valid_reg || clean.ready;
        step      = head_valid && (!emits_out || out_free);
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        finish     = 1'b0;
        if (step)
        begin
            case (cur_phase)
                PH_SPACE:
                begin
                    phase_next = body_phase(head);
                    idx_next   = '0;
                end
                PH_MAIN:
                begin
                    if ((head.kind == CMD_LIG) &&
                        (cur_idx < IDX_W'(lig_last(head.cp))))
                    begin
                        phase_next = PH_MAIN;
                        idx_next   = cur_idx + IDX_W'(1);
                    end
                    else if ((head.kind == CMD_RUN) && (head.dashes != '0))
                    begin
                        phase_next = PH_DASH;
                        idx_next   = '0;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                PH_DASH:
                begin
                    if ((cur_idx + IDX_W'(1)) < IDX_W'(head.dashes))
                    begin
                        phase_next = PH_DASH;
                        idx_next   = cur_idx + IDX_W'(1);
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                PH_END:
                begin
                    phase_next = PH_START;
                    idx_next   = '0;
                    pop        = 1'b1;
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
            if (finish)
            begin
                idx_next = '0;
                if (head.line_end)
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    phase_next = PH_START;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        ready_cp_next    = ready_cp_reg;
        ready_valid_next = ready_valid_reg;
        out_valid_next   = out_valid_reg && !clean.ready;
        out_cp_next      = out_cp_reg;
        out_end_next     = out_end_reg;
        out_empty_next   = out_empty_reg;
        if (step)
        begin
            if (emits_out)
            begin
                out_valid_next = 1'b1;
                out_cp_next    = ready_valid_reg ? ready_cp_reg : '0;
                out_end_next   = end_step;
                out_empty_next = end_step && !ready_valid_reg;
            end
            if (end_step)
            begin
                ready_valid_next = 1'b0;
            end
            else
            begin
                ready_cp_next    = push_cp;
                ready_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            idx_reg         <= '0;
            ready_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            ready_valid_reg <= ready_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ready_cp_reg  <= ready_cp_next;
        out_cp_reg    <= out_cp_next;
        out_end_reg   <= out_end_next;
        out_empty_reg <= out_empty_next;
    end

    assign clean.valid          = out_valid_reg;
    assign clean.out_code_point = out_cp_reg;
    assign clean.out_line_end   = out_end_reg;
    assign clean.line_empty     = out_empty_reg;

    a_end_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (step && end_step) |=> (!ready_valid_reg && out_valid_reg && out_end_reg))
        else $error("line end did not flush the pending code point");

    a_empty_line_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_end_reg && (out_cp_reg == '0)))
        else $error("empty-line transaction is malformed");

endmodule

@@ hdl/extracted_text_repair_filter.sv @@
// Extracted text repair filter: cleans a text line streamed one code point
// per transaction on the raw channel (code_point, line_end) and delivers the
// repaired code points on the clean channel; out_line_end marks the last one,
// and a line that leaves no text yields a single transaction with line_empty.
// The cfg channel writes the hyphen codes and the slot count; it is always
// ready and should only be written while the filter is idle.
// The front end takes one code point per cycle while the queue has room
// and no line end is pending, and decides it once the next one has
// arrived; after a line_end transaction it waits while the last one is
// decided on its own. Decisions travel through a four-entry command queue
// to the back end, which produces one code point per cycle while the
// receiver takes them: plain text gives one, a ligature two or three, a
// closed unmapped run up to one plus the number of held hyphens, a squeezed
// space one more, and the line end is a step of its own. In a steady stream
// a code point waits in the front end for its successor, passes the queue
// and back end, then waits in the ready register for a successor or line end.
// When the receiver stalls, the output register holds, the back end waits,
// the queue fills, and raw.ready drops. Reset clears the line state, the
// queue, and the configuration registers to zero.
module extracted_text_repair_filter (
    input  logic        clk,
    input  logic        rst_n,
    etr_raw_if.sink     raw,
    etr_clean_if.source clean,
    etr_cfg_if.sink     cfg
);
    import etr_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic cmd_push;
    logic q_full;
    logic head_valid;
    logic head_pop;

    etr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw),
        .cfg      (cfg),
        .cmd      (front_cmd),
        .cmd_push (cmd_push),
        .q_full   (q_full)
    );

    etr_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .push     (cmd_push),
        .full     (q_full),
        .rd_cmd   (head_cmd),
        .rd_valid (head_valid),
        .pop      (head_pop)
    );

    etr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (head_valid),
        .pop        (head_pop),
        .clean      (clean)
    );

endmodule
